>>> rtl/rle_pkg.sv
package rle_pkg;

    // default width of the pixel counters and of the run length
    localparam int PIXEL_COUNT_BITS_DEF = 24;

    // register port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_WORD_LSB  = 2;
    localparam logic REG_IDX_PIXEL_COUNT = 1'b0;

    // header byte fields
    localparam int HDR_RUN_BIT   = 7;
    localparam int HDR_CLEAR_BIT = 6;
    localparam logic [5:0] HDR_FILL_MASK = 6'h3F;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR   = 8'd0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rle_pixel_t;

endpackage

>>> rtl/rle_apb_regs.sv
module rle_apb_regs #(
    parameter int PIXEL_COUNT_BITS = rle_pkg::PIXEL_COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rle_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [rle_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [rle_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output logic [PIXEL_COUNT_BITS-1:0]        pixel_count
);

    logic [PIXEL_COUNT_BITS-1:0] pixel_count_reg;
    logic                        reg_idx;
    logic                        wr_en;

    assign reg_idx = paddr[rle_pkg::APB_WORD_LSB];
    assign wr_en   = psel && penable && pwrite && (reg_idx == rle_pkg::REG_IDX_PIXEL_COUNT);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= PIXEL_COUNT_BITS'(1);
        end else if (wr_en) begin
            pixel_count_reg <= pwdata[PIXEL_COUNT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == rle_pkg::REG_IDX_PIXEL_COUNT) begin
            prdata = rle_pkg::APB_DATA_BITS'(pixel_count_reg);
        end
    end

    assign pixel_count = pixel_count_reg;

endmodule

>>> rtl/rle_decode.sv
module rle_decode #(
    parameter int PIXEL_COUNT_BITS = rle_pkg::PIXEL_COUNT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [PIXEL_COUNT_BITS-1:0] pixel_count,
    input  logic [7:0]                  code_byte,
    input  logic                        step,
    output logic                        emit,
    output rle_pkg::rle_pixel_t         pixel,
    output logic [PIXEL_COUNT_BITS-1:0] run_length,
    output logic                        image_done
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_FILL    = 2'd2
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [PIXEL_COUNT_BITS-1:0] pixels_left_reg, pixels_left_next;
    logic [6:0]                  literal_left_reg, literal_left_next;
    logic [5:0]                  fill_left_reg, fill_left_next;
    logic [1:0]                  byte_index_reg, byte_index_next;
    logic [7:0]                  blue_hold_reg, blue_hold_next;
    logic [7:0]                  green_hold_reg, green_hold_next;

    logic [PIXEL_COUNT_BITS-1:0] count_eff;
    logic [PIXEL_COUNT_BITS-1:0] left_eff;
    logic [PIXEL_COUNT_BITS-1:0] left_after;
    logic [PIXEL_COUNT_BITS-1:0] run_cand;
    logic [PIXEL_COUNT_BITS-1:0] clip_n;

    // a new image loads its length from the register, zero counts as one
    assign count_eff = (pixel_count == '0) ? PIXEL_COUNT_BITS'(1) : pixel_count;
    assign left_eff  = (pixels_left_reg == '0) ? count_eff : pixels_left_reg;

    always_comb begin
        case (phase_reg)
            PH_FILL:    run_cand = PIXEL_COUNT_BITS'(fill_left_reg);
            PH_LITERAL: run_cand = PIXEL_COUNT_BITS'(1);
            default:    run_cand = PIXEL_COUNT_BITS'(code_byte[5:0] & rle_pkg::HDR_FILL_MASK);
        endcase
    end

    assign clip_n = (run_cand < left_eff) ? run_cand : left_eff;

    always_comb begin
        phase_next        = phase_reg;
        literal_left_next = literal_left_reg;
        fill_left_next    = fill_left_reg;
        byte_index_next   = byte_index_reg;
        blue_hold_next    = blue_hold_reg;
        green_hold_next   = green_hold_reg;
        emit              = 1'b0;
        pixel             = '0;
        run_length        = clip_n;

        case (phase_reg)
            PH_LITERAL, PH_FILL: begin
                case (byte_index_reg)
                    2'd0: begin
                        blue_hold_next  = code_byte;
                        byte_index_next = 2'd1;
                    end
                    2'd1: begin
                        green_hold_next = code_byte;
                        byte_index_next = 2'd2;
                    end
                    default: begin
                        byte_index_next = 2'd0;
                        emit            = 1'b1;
                        pixel.red       = code_byte;
                        pixel.green     = green_hold_reg;
                        pixel.blue      = blue_hold_reg;
                        pixel.alpha     = rle_pkg::ALPHA_OPAQUE;
                        if (phase_reg == PH_FILL) begin
                            phase_next     = PH_HEADER;
                            fill_left_next = '0;
                        end else begin
                            literal_left_next = literal_left_reg - 7'd1;
                            if (literal_left_next == '0) begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                endcase
            end
            default: begin
                phase_next = PH_HEADER;
                if (code_byte[6:0] == '0) begin
                    // end marker pads the rest of the image
                    emit        = 1'b1;
                    pixel.alpha = rle_pkg::ALPHA_CLEAR;
                    run_length  = left_eff;
                end else if (code_byte[rle_pkg::HDR_RUN_BIT]) begin
                    if (code_byte[rle_pkg::HDR_CLEAR_BIT]) begin
                        emit        = (code_byte[5:0] != '0);
                        pixel.alpha = rle_pkg::ALPHA_CLEAR;
                    end else begin
                        fill_left_next  = code_byte[5:0] & rle_pkg::HDR_FILL_MASK;
                        phase_next      = PH_FILL;
                        byte_index_next = 2'd0;
                    end
                end else begin
                    literal_left_next = code_byte[6:0];
                    phase_next        = PH_LITERAL;
                    byte_index_next   = 2'd0;
                end
            end
        endcase

        left_after       = left_eff - run_length;
        pixels_left_next = left_eff;
        image_done       = 1'b0;
        if (emit) begin
            pixels_left_next = left_after;
            image_done       = (left_after == '0);
            if (image_done) begin
                phase_next        = PH_HEADER;
                literal_left_next = '0;
                fill_left_next    = '0;
                byte_index_next   = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            pixels_left_reg  <= '0;
            literal_left_reg <= '0;
            fill_left_reg    <= '0;
            byte_index_reg   <= 2'd0;
            blue_hold_reg    <= '0;
            green_hold_reg   <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            pixels_left_reg  <= pixels_left_next;
            literal_left_reg <= literal_left_next;
            fill_left_reg    <= fill_left_next;
            byte_index_reg   <= byte_index_next;
            blue_hold_reg    <= blue_hold_next;
            green_hold_reg   <= green_hold_next;
        end
    end

`ifndef ASSERT_OFF
    // inside a pixel body the image always has pixels left
    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HEADER) |-> (pixels_left_reg != '0))
        else $error("pixel body with no pixels left");

    a_byte_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_index_reg != 2'd3))
        else $error("byte index out of range");

    a_run_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (run_length != '0 && run_length <= left_eff))
        else $error("run exceeds pixels left");
`endif

endmodule

>>> rtl/rle_pixel_decoder_core.sv
// channel  | ports                                         | width
// ---------+-----------------------------------------------+----------------------------
// input    | s_valid s_ready s_code_byte                   | 8 bit code byte
// result   | m_valid m_ready m_red m_green m_blue m_alpha  | 4x8 bit pixel,
//          | m_run_length m_image_done                     | PIXEL_COUNT_BITS run, 1 bit
// config   | psel penable pwrite paddr pwdata prdata pready| 32 bit, pixel_count at 0x0
//
// one code byte per cycle while no run waits untaken: the byte is registered, decoded
// against the run counters in one pass and the run lands in the result register
// a run shows on m_valid once its code byte has passed the input register and been decoded into the result register
// a byte that yields a run waits in the input register while the previous run is untaken
// aresetn is synchronous; it clears the decoder state and sets pixel_count to one
module rle_pixel_decoder_core #(
    parameter int PIXEL_COUNT_BITS = rle_pkg::PIXEL_COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_code_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_red,
    output logic [7:0]                         m_green,
    output logic [7:0]                         m_blue,
    output logic [7:0]                         m_alpha,
    output logic [PIXEL_COUNT_BITS-1:0]        m_run_length,
    output logic                               m_image_done,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rle_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [rle_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [rle_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    logic [PIXEL_COUNT_BITS-1:0] pixel_count;

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;

    logic                        out_valid_reg;
    rle_pkg::rle_pixel_t         out_pixel_reg;
    logic [PIXEL_COUNT_BITS-1:0] out_run_reg;
    logic                        out_done_reg;

    logic                        step;
    logic                        dec_emit;
    rle_pkg::rle_pixel_t         dec_pixel;
    logic [PIXEL_COUNT_BITS-1:0] dec_run;
    logic                        dec_done;

    rle_apb_regs #(
        .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_count (pixel_count)
    );

    rle_decode #(
        .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pixel_count (pixel_count),
        .code_byte   (in_byte_reg),
        .step        (step),
        .emit        (dec_emit),
        .pixel       (dec_pixel),
        .run_length  (dec_run),
        .image_done  (dec_done)
    );

    // a byte that yields no run never waits for the result side
    assign step    = in_valid_reg && (!out_valid_reg || m_ready || !dec_emit);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step && dec_emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_code_byte;
        end
        if (step && dec_emit) begin
            out_pixel_reg <= dec_pixel;
            out_run_reg   <= dec_run;
            out_done_reg  <= dec_done;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_red        = out_pixel_reg.red;
    assign m_green      = out_pixel_reg.green;
    assign m_blue       = out_pixel_reg.blue;
    assign m_alpha      = out_pixel_reg.alpha;
    assign m_run_length = out_run_reg;
    assign m_image_done = out_done_reg;

`ifndef ASSERT_OFF
    // input side only stalls behind a pending, untaken run
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !s_ready) |-> (out_valid_reg && !m_ready && dec_emit))
        else $error("input stalled without a pending result");

    a_run_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && dec_emit) |=> (m_valid && m_run_length == $past(dec_run)))
        else $error("decoded run not presented");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_run_length != '0))
        else $error("empty run presented");
`endif

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PCB = rle_pkg::PIXEL_COUNT_BITS_DEF;
    localparam logic [rle_pkg::APB_ADDR_BITS-1:0] PIXEL_COUNT_ADDR =
        rle_pkg::APB_ADDR_BITS'(rle_pkg::REG_IDX_PIXEL_COUNT) << rle_pkg::APB_WORD_LSB;

    // header byte codes
    localparam logic [7:0] HDR_END_LIT  = 8'h00;
    localparam logic [7:0] HDR_FILL     = 8'(1 << rle_pkg::HDR_RUN_BIT);
    localparam logic [7:0] HDR_END_FILL = HDR_FILL;
    localparam logic [7:0] HDR_CLEAR    = HDR_FILL | 8'(1 << rle_pkg::HDR_CLEAR_BIT);
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_LITERAL,
        DEC_FILL
    } dec_phase_t;

    typedef struct packed {
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic [7:0]     alpha;
        logic [PCB-1:0] run_length;
        logic           image_done;
    } rle_run_t;

    class rle_scoreboard_t;
        logic [PCB-1:0] pixel_count;
        logic [PCB-1:0] pixels_left;
        dec_phase_t     phase;
        logic [6:0]     literal_left;
        logic [5:0]     fill_left;
        logic [1:0]     byte_index;
        logic [7:0]     blue_hold;
        logic [7:0]     green_hold;
        rle_run_t       runs_due[$];
        int             errors;
        int             bytes_seen;
        int             runs_checked;
        int             images_done;

        function new();
            pixel_count  = PCB'(1);
            pixels_left  = '0;
            phase        = DEC_HEADER;
            literal_left = '0;
            fill_left    = '0;
            byte_index   = '0;
            blue_hold    = '0;
            green_hold   = '0;
        endfunction

        function int pending();
            return runs_due.size();
        endfunction

        function logic [PCB-1:0] clip(logic [PCB-1:0] n);
            return (n < pixels_left) ? n : pixels_left;
        endfunction

        function void emit_run(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               logic [7:0] a, logic [PCB-1:0] n);
            rle_run_t run;
            pixels_left = pixels_left - n;
            run = '{red: r, green: g, blue: b, alpha: a, run_length: n,
                    image_done: (pixels_left == 0)};
            runs_due.push_back(run);
            if (pixels_left == 0) begin
                phase        = DEC_HEADER;
                literal_left = '0;
                fill_left    = '0;
                byte_index   = '0;
            end
        endfunction

        function void decode_byte(logic [7:0] code);
            logic [5:0] n;
            bytes_seen++;
            if (phase == DEC_HEADER) begin
                // a new image loads its size on its first header
                if (pixels_left == 0)
                    pixels_left = (pixel_count == 0) ? PCB'(1) : pixel_count;
                n = code[5:0] & rle_pkg::HDR_FILL_MASK;
                if (code == HDR_END_LIT || code == HDR_END_FILL) begin
                    emit_run(8'd0, 8'd0, 8'd0, rle_pkg::ALPHA_CLEAR, pixels_left);
                end else if (code[rle_pkg::HDR_RUN_BIT]) begin
                    if (code[rle_pkg::HDR_CLEAR_BIT]) begin
                        if (n != 0)
                            emit_run(8'd0, 8'd0, 8'd0, rle_pkg::ALPHA_CLEAR,
                                     clip(PCB'(n)));
                    end else begin
                        fill_left  = n;
                        phase      = DEC_FILL;
                        byte_index = 2'd0;
                    end
                end else begin
                    literal_left = code[6:0];
                    phase        = DEC_LITERAL;
                    byte_index   = 2'd0;
                end
            end else if (byte_index == 2'd0) begin
                blue_hold  = code;
                byte_index = 2'd1;
            end else if (byte_index == 2'd1) begin
                green_hold = code;
                byte_index = 2'd2;
            end else begin
                byte_index = 2'd0;
                if (phase == DEC_FILL) begin
                    phase     = DEC_HEADER;
                    n         = fill_left;
                    fill_left = '0;
                    emit_run(code, green_hold, blue_hold, rle_pkg::ALPHA_OPAQUE,
                             clip(PCB'(n)));
                end else begin
                    literal_left = literal_left - 7'd1;
                    if (literal_left == 0)
                        phase = DEC_HEADER;
                    emit_run(code, green_hold, blue_hold, rle_pkg::ALPHA_OPAQUE,
                             clip(PCB'(1)));
                end
            end
        endfunction

        function void check_run(rle_run_t got);
            rle_run_t want;
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected run r %02h g %02h b %02h a %02h len %0d done %0b",
                         $time, got.red, got.green, got.blue, got.alpha,
                         got.run_length, got.image_done);
                errors++;
                return;
            end
            want = runs_due.pop_front();
            runs_checked++;
            if (want.image_done)
                images_done++;
            if (got !== want) begin
                $display("%0t: run mismatch expected r %02h g %02h b %02h a %02h len %0d done %0b",
                         $time, want.red, want.green, want.blue, want.alpha,
                         want.run_length, want.image_done);
                $display("%0t:                 actual r %02h g %02h b %02h a %02h len %0d done %0b",
                         $time, got.red, got.green, got.blue, got.alpha,
                         got.run_length, got.image_done);
                errors++;
            end
        endfunction
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [7:0]                        s_code_byte = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [7:0]                        m_red;
    logic [7:0]                        m_green;
    logic [7:0]                        m_blue;
    logic [7:0]                        m_alpha;
    logic [PCB-1:0]                    m_run_length;
    logic                              m_image_done;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [rle_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [rle_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [rle_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;

    rle_scoreboard_t sb = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int count_settings = 0;

    rle_pixel_decoder_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_byte  (s_code_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_run_length (m_run_length),
        .m_image_done (m_image_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // result side: check each run transaction, then pick the next ready
    initial begin
        rle_run_t got;
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = '{red: m_red, green: m_green, blue: m_blue, alpha: m_alpha,
                        run_length: m_run_length, image_done: m_image_done};
                sb.check_run(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send_byte(input logic [7:0] code);
        while (!calm && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_code_byte <= code;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.decode_byte(code);
    endtask

    task automatic send_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    // stop offering and let every run drain before touching the register
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_pixel_count(input logic [PCB-1:0] value);
        logic [rle_pkg::APB_DATA_BITS-1:0] readback;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PIXEL_COUNT_ADDR;
        pwdata  <= rle_pkg::APB_DATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        sb.pixel_count = value;
        count_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[PCB-1:0] !== value) begin
            $display("%0t: pixel_count readback expected %0d actual %0d",
                     $time, value, readback[PCB-1:0]);
            sb.errors++;
        end
    endtask

    task automatic send_random_token(input int room);
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 35) begin
            n = ($urandom_range(11) == 0) ? $urandom_range(127, 1) : $urandom_range(4, 1);
            // keep a long literal inside the byte budget of the pass
            if (3 * n + 1 > room)
                n = (room > 4) ? (room - 1) / 3 : 1;
            send_byte(8'(n));
            send_random_bytes(3 * n);
        end else if (pick < 60) begin
            send_byte(HDR_FILL | 8'($urandom_range(63, 1)));
            send_random_bytes(3);
        end else if (pick < 75) begin
            send_byte(HDR_CLEAR | 8'($urandom_range(63)));
        end else if (pick < 82) begin
            send_byte($urandom_range(1) ? HDR_END_FILL : HDR_END_LIT);
        end else if (pick < 92) begin
            // truncated literal or fill, the next header lands in the color bytes
            if ($urandom_range(1))
                send_byte(8'($urandom_range(127, 1)));
            else
                send_byte(HDR_FILL | 8'($urandom_range(63, 1)));
            send_random_bytes($urandom_range(2));
        end else begin
            send_random_bytes(1);
        end
    endtask

    initial begin
        int unsigned quota [7];
        logic [PCB-1:0] value;
        int start;
        int guard;

        quota = '{70, 150, 100, 40, 250, 150, 190};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // count of one from reset, end marker opens the image
        send_byte(HDR_END_LIT);
        send_byte(HDR_CLEAR);
        send_byte(HDR_CLEAR | 8'h3F);
        send_byte(HDR_FILL | 8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hAA);

        set_pixel_count('0);
        send_byte(HDR_END_FILL);

        // a literal longer than the image is cut at the image end and the next byte opens the next image
        set_pixel_count(PCB'(2));
        send_byte(8'h7F);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);

        // new count written mid image applies to the following image only
        set_pixel_count({PCB{1'b1}});
        send_byte(HDR_END_LIT);
        send_byte(HDR_END_FILL);
        send_byte(HDR_FILL | 8'h3F);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(HDR_END_LIT);

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: value = PCB'(1);
                1: value = PCB'(3);
                2: value = {PCB{1'b1}};
                3: value = '0;
                4: value = PCB'(40);
                5: value = PCB'(255);
                default: value = PCB'($urandom_range(500, 2));
            endcase
            set_pixel_count(value);
            calm = (p == 4);
            if (p == 5)
                hold_req = 1'b1;
            start = sb.bytes_seen;
            while (sb.bytes_seen - start < quota[p])
                send_random_token(int'(quota[p]) - (sb.bytes_seen - start));
        end
        calm = 1'b0;

        s_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected runs never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("summary: %0d code bytes, %0d runs checked, %0d images completed",
                 sb.bytes_seen, sb.runs_checked, sb.images_done);
        $display("summary: %0d pixel_count settings incl. zero and full scale, %0d errors",
                 count_settings, sb.errors);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
